/* src/rfd_pkg.sv */
// Package for the response frame decoder: beat payload types, the action
// entry that travels from the front to the back, error codes and byte constants.
// No dependencies.
package rfd_pkg;

   // Character constants used by the framing logic.
   localparam logic [7:0] CHAR_DASH = 8'h2D;
   localparam logic [7:0] CHAR_A    = 8'h41;
   localparam logic [7:0] CHAR_B    = 8'h42;
   localparam logic [7:0] CHAR_C    = 8'h43;
   localparam logic [7:0] CHAR_D    = 8'h44;
   localparam logic [7:0] CHAR_F    = 8'h46;
   localparam logic [7:0] CHAR_L    = 8'h4C;
   localparam logic [7:0] CHAR_T    = 8'h54;

   // Saturation limits of the position and payload counters.
   localparam logic [16:0] POS_MAX = 17'h1FFFF;
   localparam logic [15:0] CNT_MAX = 16'hFFFF;

   // Register map.
   localparam logic [0:0] REG_PROTOCOL_MODE = 1'b0;

   // Error codes reported in the status beat.
   typedef enum logic [3:0] {
      ERR_NONE  = 4'd0,
      ERR_A     = 4'd1,
      ERR_B     = 4'd2,
      ERR_C     = 4'd3,
      ERR_D     = 4'd4,
      ERR_F     = 4'd5,
      ERR_L     = 4'd6,
      ERR_T     = 4'd7,
      ERR_UNDEF = 4'd8
   } rfd_err_type;

   // Input beat.
   typedef struct packed {
      logic [7:0] rx_byte;
      logic       frame_end;
   } rfd_req_type;

   // Result beat.
   typedef struct packed {
      logic        kind;
      logic [7:0]  payload_byte;
      logic        last;
      logic        failed;
      logic [3:0]  error_code;
      logic [15:0] length_field;
      logic [7:0]  check_byte;
      logic        checksum_ok;
      logic        malformed;
      logic [15:0] payload_count;
   } rfd_rsp_type;

   // Work for the back part: an optional payload byte and an optional status.
   typedef struct packed {
      logic        has_payload;
      logic [7:0]  payload_byte;
      logic        has_status;
      logic        failed;
      rfd_err_type error_code;
      logic [15:0] length_field;
      logic [7:0]  check_byte;
      logic        checksum_ok;
      logic        malformed;
      logic [15:0] payload_count;
   } rfd_action_type;

   // Push from the front into the queue.
   typedef struct packed {
      logic           valid;
      rfd_action_type action;
   } rfd_push_type;

   // Queue fill status.
   typedef struct packed {
      logic empty;
      logic full;
   } rfd_qstat_type;

   // Maps the letter after the error marker to its code.
   function automatic rfd_err_type letter_code(input logic [7:0] c);
      rfd_err_type code;
      case (c)
         CHAR_A:  code = ERR_A;
         CHAR_B:  code = ERR_B;
         CHAR_C:  code = ERR_C;
         CHAR_D:  code = ERR_D;
         CHAR_F:  code = ERR_F;
         CHAR_L:  code = ERR_L;
         CHAR_T:  code = ERR_T;
         default: code = ERR_UNDEF;
      endcase
      return code;
   endfunction

endpackage

/* src/rfd_front.sv */
// Front part of the response frame decoder: accepts bytes, tracks the frame
// position, delay line, checksum and error marker, and pushes actions.
// Depends on rfd_pkg.
module rfd_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [1:0]            mode,
   input  logic                  req_valid,
   input  rfd_pkg::rfd_req_type  req_data,
   output logic                  req_stall,
   input  rfd_pkg::rfd_qstat_type qstat,
   output rfd_pkg::rfd_push_type push
);
   import rfd_pkg::*;

   logic [16:0] pos_ff, pos_in;
   logic [7:0]  held0_ff, held0_in;
   logic [7:0]  held1_ff, held1_in;
   logic [7:0]  sum_ff, sum_in;
   logic [15:0] length_ff, length_in;
   logic        dash_ff, dash_in;
   logic        pend_ff, pend_in;
   logic [7:0]  letter_ff, letter_in;
   logic [15:0] count_ff, count_in;

   logic        accept;
   logic        lenp;
   logic        chk;
   logic [2:0]  hdr;
   logic [2:0]  thresh;
   logic        emit;
   logic [7:0]  emit_byte;
   logic        malformed;
   logic [7:0]  c;
   logic        frame_end;

   // The front pushes at most one action per beat, so a full queue stalls input.
   assign req_stall = qstat.full;
   assign accept    = req_valid && !qstat.full;

   assign c         = req_data.rx_byte;
   assign frame_end = req_data.frame_end;
   assign lenp      = mode[0];
   assign chk       = mode[1];
   assign hdr       = lenp ? 3'd3 : 3'd1;
   // A body byte leaves the delay line once the header and the line are full.
   assign thresh    = hdr + {2'b00, chk} + 3'd1;
   assign malformed = pos_ff < ({14'd0, hdr} + {16'd0, chk});
   assign emit      = pos_ff >= {14'd0, thresh};
   assign emit_byte = chk ? held1_ff : held0_ff;

   // Per-byte state update and action generation.
   always_comb begin
      pos_in    = pos_ff;
      held0_in  = held0_ff;
      held1_in  = held1_ff;
      sum_in    = sum_ff;
      length_in = length_ff;
      dash_in   = dash_ff;
      pend_in   = pend_ff;
      letter_in = letter_ff;
      count_in  = count_ff;
      push      = '0;

      // The first dash marks the frame failed; the next byte is the letter.
      if (pend_ff) begin
         letter_in = c;
         pend_in   = 1'b0;
      end else if (!dash_ff && c == CHAR_DASH) begin
         dash_in = 1'b1;
         pend_in = 1'b1;
      end

      // Payload byte leaving the delay line, with its effect on sum and count.
      if (emit) begin
         sum_in = sum_ff + emit_byte;
         if (count_ff != CNT_MAX) begin
            count_in = count_ff + 16'd1;
         end
      end

      if (!frame_end) begin
         if (lenp && pos_ff == 17'd1) begin
            length_in = {c, 8'h00};
         end else if (lenp && pos_ff == 17'd2) begin
            length_in = length_ff | {8'h00, c};
         end
         if (pos_ff >= {14'd0, hdr}) begin
            held1_in = held0_ff;
            held0_in = c;
         end
         if (pos_ff != POS_MAX) begin
            pos_in = pos_ff + 17'd1;
         end
         push.valid                = emit;
         push.action.has_payload   = emit;
         push.action.payload_byte  = emit_byte;
      end else begin
         push.valid                = 1'b1;
         push.action.has_payload   = emit;
         push.action.payload_byte  = emit_byte;
         push.action.has_status    = 1'b1;
         push.action.failed        = dash_in;
         push.action.error_code    = dash_in ? letter_code(letter_in) : ERR_NONE;
         push.action.length_field  = (!malformed && lenp) ? length_ff : 16'd0;
         push.action.check_byte    = (!malformed && chk) ? held0_ff : 8'd0;
         push.action.checksum_ok   = !malformed && chk && (sum_in == held0_ff);
         push.action.malformed     = malformed;
         push.action.payload_count = count_in;
         // Every frame starts from a clean state.
         pos_in    = '0;
         held0_in  = '0;
         held1_in  = '0;
         sum_in    = '0;
         length_in = '0;
         dash_in   = 1'b0;
         pend_in   = 1'b0;
         letter_in = '0;
         count_in  = '0;
      end

      if (!accept) begin
         push.valid = 1'b0;
      end
   end

   // Frame state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         held0_ff  <= '0;
         held1_ff  <= '0;
         sum_ff    <= '0;
         length_ff <= '0;
         dash_ff   <= 1'b0;
         pend_ff   <= 1'b0;
         letter_ff <= '0;
         count_ff  <= '0;
      end else if (accept) begin
         pos_ff    <= pos_in;
         held0_ff  <= held0_in;
         held1_ff  <= held1_in;
         sum_ff    <= sum_in;
         length_ff <= length_in;
         dash_ff   <= dash_in;
         pend_ff   <= pend_in;
         letter_ff <= letter_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* src/rfd_queue.sv */
// Short action queue between the front and back parts of the decoder.
// Depends on rfd_pkg.
module rfd_queue #(
   parameter int DEPTH = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rfd_pkg::rfd_push_type  push,
   input  logic                   pop,
   output rfd_pkg::rfd_action_type head,
   output rfd_pkg::rfd_qstat_type qstat
);
   import rfd_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   rfd_action_type         entry_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       fill_ff, fill_in;
   logic                   do_push;
   logic                   do_pop;

   assign qstat.empty = (fill_ff == '0);
   assign qstat.full  = (fill_ff == CNT_W'(DEPTH));
   assign do_push     = push.valid && !qstat.full;
   assign do_pop      = pop && !qstat.empty;
   assign head        = entry_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.action;
      end
   end

endmodule

/* src/rfd_back.sv */
// Back part of the response frame decoder: turns queued actions into result
// beats through an output register. Depends on rfd_pkg.
module rfd_back (
   input  logic                    clock,
   input  logic                    reset,
   input  rfd_pkg::rfd_action_type head,
   input  rfd_pkg::rfd_qstat_type  qstat,
   output logic                    pop,
   output logic                    rsp_valid,
   output rfd_pkg::rfd_rsp_type    rsp_data,
   input  logic                    rsp_stall
);
   import rfd_pkg::*;

   logic        rsp_valid_ff, rsp_valid_in;
   rfd_rsp_type rsp_data_ff, rsp_data_in;
   logic        split_ff, split_in;
   logic        load;

   // The output register takes a new beat when empty or when its beat leaves.
   assign load      = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // An action with both parts sends its payload beat first, then its status.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      split_in     = split_ff;
      pop          = 1'b0;
      if (load) begin
         rsp_valid_in = !qstat.empty;
         if (!qstat.empty) begin
            rsp_data_in = '0;
            if (head.has_payload && !split_ff) begin
               rsp_data_in.payload_byte = head.payload_byte;
               if (head.has_status) begin
                  split_in = 1'b1;
               end else begin
                  pop = 1'b1;
               end
            end else begin
               rsp_data_in.kind          = 1'b1;
               rsp_data_in.last          = 1'b1;
               rsp_data_in.failed        = head.failed;
               rsp_data_in.error_code    = head.error_code;
               rsp_data_in.length_field  = head.length_field;
               rsp_data_in.check_byte    = head.check_byte;
               rsp_data_in.checksum_ok   = head.checksum_ok;
               rsp_data_in.malformed     = head.malformed;
               rsp_data_in.payload_count = head.payload_count;
               split_in = 1'b0;
               pop      = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         split_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         split_ff     <= split_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule

/* src/response_frame_decoder.sv */
// Top level of the response frame decoder: configuration register, front part,
// action queue and back part. Depends on rfd_pkg, rfd_front, rfd_queue, rfd_back.
//
// The decoder takes one frame byte per cycle while the queue is not full and
// emits each payload byte one or two bytes later, followed by a status beat on
// the final byte of each frame. The front part writes at most one action per
// byte into a QUEUE_DEPTH-entry queue; the back part drains one result beat per
// cycle through its output register while output is not stalled. A final byte
// that still releases a payload byte yields two beats, which the queue absorbs,
// so the sustained rate is one byte per cycle while output is not stalled.
// Input stalls only when the queue is full. The protocol_mode register at byte
// address 0 should be written only between frames while no beats are in
// flight.
module response_frame_decoder #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  rfd_pkg::rfd_req_type req_data,
   output logic                 req_stall,
   output logic                 rsp_valid,
   output rfd_pkg::rfd_rsp_type rsp_data,
   input  logic                 rsp_stall,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [2:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);
   import rfd_pkg::*;

   logic [1:0]     mode_ff, mode_in;
   rfd_push_type   push;
   rfd_action_type head;
   rfd_qstat_type  qstat;
   logic           pop;

   // Configuration register write and read back.
   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_PROTOCOL_MODE) ? {30'd0, mode_ff} : 32'd0;

   always_comb begin
      mode_in = mode_ff;
      if (psel && penable && pwrite && paddr[2] == REG_PROTOCOL_MODE) begin
         mode_in = pwdata[1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= '0;
      end else begin
         mode_ff <= mode_in;
      end
   end

   rfd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .mode      (mode_ff),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .qstat     (qstat),
      .push      (push)
   );

   rfd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .qstat (qstat)
   );

   rfd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .qstat     (qstat),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

   // The front never pushes into a full queue.
   assert property (@(posedge clock) disable iff (reset) push.valid |-> !qstat.full)
      else $error("action pushed into a full queue");

   // The back never pops an empty queue.
   assert property (@(posedge clock) disable iff (reset) pop |-> !qstat.empty)
      else $error("action popped from an empty queue");

   // A payload beat carries no status information.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.kind) |->
         (!rsp_data.last && !rsp_data.failed && rsp_data.payload_count == 16'd0
          && !rsp_data.malformed))
      else $error("payload beat carries status fields");

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the response frame decoder: drives frame bytes,
// predicts payload and status beats per framing mode and checks every result.
// Depends on rfd_pkg and response_frame_decoder.
module testbench;
   import rfd_pkg::*;

   localparam logic [2:0] MODE_ADDR      = {REG_PROTOCOL_MODE, 2'b00};
   localparam logic [2:0] UNUSED_ADDR    = 3'd4;
   localparam int         WATCHDOG_LIMIT = 4000;
   localparam int         HOLDOFF_CYCLES = 150;
   localparam int         SETTLE_CYCLES  = 16;
   localparam int         LONG_FRAME_LEN = 200;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   rfd_req_type req_data = '0;
   logic        req_stall;
   logic        rsp_valid;
   rfd_rsp_type rsp_data;
   logic        rsp_stall = 1'b0;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   // Stimulus and expectation stores.
   rfd_req_type pending_beats[$];
   rfd_rsp_type expected_beats[$];

   // Decoder state as this bench tracks it.
   logic [1:0]  mode_q = '0;
   logic [16:0] frame_pos = '0;
   logic [7:0]  held0 = '0;
   logic [7:0]  held1 = '0;
   logic [7:0]  pay_sum = '0;
   logic [15:0] len_q = '0;
   logic        dash_q = 1'b0;
   logic        letter_due = 1'b0;
   logic [7:0]  letter_q = '0;
   logic [15:0] pay_count = '0;

   // Run bookkeeping.
   int  error_count = 0;
   int  beats_in = 0;
   int  beats_queued = 0;
   int  payload_beats = 0;
   int  status_beats = 0;
   int  quiet_cycles = 0;
   int  holdoff_left = 0;
   bit  holdoff_done = 1'b0;
   bit  steady = 1'b0;
   bit  req_fire = 1'b0;

   response_frame_decoder DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   // Clock and a single reset pulse at the start.
   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // Maps the letter that follows the error marker to its status code.
   function automatic rfd_err_type decode_letter(input logic [7:0] c);
      case (c)
         CHAR_A:  return ERR_A;
         CHAR_B:  return ERR_B;
         CHAR_C:  return ERR_C;
         CHAR_D:  return ERR_D;
         CHAR_F:  return ERR_F;
         CHAR_L:  return ERR_L;
         CHAR_T:  return ERR_T;
         default: return ERR_UNDEF;
      endcase
   endfunction

   // Queues a payload beat and folds it into the checksum and count.
   task automatic push_payload(input logic [7:0] b);
      rfd_rsp_type r;
      r = '0;
      r.payload_byte = b;
      expected_beats.push_back(r);
      pay_sum = pay_sum + b;
      if (pay_count != CNT_MAX) pay_count = pay_count + 16'd1;
   endtask

   // Works out the beats that one accepted frame byte releases.
   task automatic predict_frame_byte(input rfd_req_type beat);
      logic        has_len;
      logic        has_chk;
      int          hdr;
      int          depth;
      int          pos;
      rfd_rsp_type st;
      has_len = mode_q[0];
      has_chk = mode_q[1];
      hdr = has_len ? 3 : 1;
      depth = has_chk ? 2 : 1;
      pos = frame_pos;

      // Only the first marker counts; the byte after it is the letter.
      if (letter_due) begin
         letter_q = beat.rx_byte;
         letter_due = 1'b0;
      end else if (!dash_q && beat.rx_byte == CHAR_DASH) begin
         dash_q = 1'b1;
         letter_due = 1'b1;
      end

      if (!beat.frame_end) begin
         // Header bytes build the length; body bytes go through the delay line.
         if (has_len && pos == 1) len_q = {beat.rx_byte, 8'h00};
         else if (has_len && pos == 2) len_q = len_q | {8'h00, beat.rx_byte};
         if (pos >= hdr) begin
            if (pos - hdr >= depth) push_payload(has_chk ? held1 : held0);
            held1 = held0;
            held0 = beat.rx_byte;
         end
         if (frame_pos != POS_MAX) frame_pos = frame_pos + 17'd1;
      end else begin
         // Final byte: flush a due payload byte, then report the frame.
         st = '0;
         st.kind = 1'b1;
         st.last = 1'b1;
         st.failed = dash_q;
         st.error_code = dash_q ? decode_letter(letter_q) : ERR_NONE;
         st.malformed = (pos < hdr + int'(has_chk));
         if (!st.malformed) begin
            if (pos - hdr > int'(has_chk)) push_payload(has_chk ? held1 : held0);
            if (has_chk) begin
               st.check_byte = held0;
               st.checksum_ok = (pay_sum == held0);
            end
            if (has_len) st.length_field = len_q;
         end
         st.payload_count = pay_count;
         expected_beats.push_back(st);
         frame_pos = '0;
         held0 = '0;
         held1 = '0;
         pay_sum = '0;
         len_q = '0;
         dash_q = 1'b0;
         letter_due = 1'b0;
         letter_q = '0;
         pay_count = '0;
      end
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         error_count++;
      end
   endtask

   // Compares one result beat with the oldest expectation.
   task automatic check_result(input rfd_rsp_type got);
      rfd_rsp_type want;
      if (expected_beats.size() == 0) begin
         $error("result beat with nothing expected: %h", got);
         error_count++;
      end else begin
         want = expected_beats.pop_front();
         check_field("kind", want.kind, got.kind);
         check_field("payload_byte", want.payload_byte, got.payload_byte);
         check_field("last", want.last, got.last);
         check_field("failed", want.failed, got.failed);
         check_field("error_code", want.error_code, got.error_code);
         check_field("length_field", want.length_field, got.length_field);
         check_field("check_byte", want.check_byte, got.check_byte);
         check_field("checksum_ok", want.checksum_ok, got.checksum_ok);
         check_field("malformed", want.malformed, got.malformed);
         check_field("payload_count", want.payload_count, got.payload_count);
         if (got.kind) status_beats++;
         else payload_beats++;
      end
   endtask

   // Sender: offers the next byte at the falling edge, idling at random.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (pending_beats.size() > 0 && (steady || $urandom_range(99) >= 24)) begin
            req_data <= pending_beats.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, one long hold-off once traffic is under way.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (holdoff_left > 0) begin
         rsp_stall <= 1'b1;
         holdoff_left <= holdoff_left - 1;
      end else if (!holdoff_done && beats_in >= 400) begin
         rsp_stall <= 1'b1;
         holdoff_left <= HOLDOFF_CYCLES;
         holdoff_done <= 1'b1;
      end else begin
         rsp_stall <= !steady && ($urandom_range(99) < 24);
      end
   end

   // Monitor: checks results, predicts from accepted bytes, watches for hangs.
   always @(posedge clock) begin
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_valid && !req_stall;
         if (rsp_valid && !rsp_stall) check_result(rsp_data);
         if (req_valid && !req_stall) begin
            predict_frame_byte(req_data);
            beats_in++;
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
               $display("Timeout after %0d idle cycles", quiet_cycles);
               $display("DONE: errors detected");
               $finish;
            end
         end
      end
   end

   // Stimulus helpers.
   task automatic add_beat(input logic [7:0] b, input logic fin);
      rfd_req_type r;
      r.rx_byte = b;
      r.frame_end = fin;
      pending_beats.push_back(r);
      beats_queued++;
   endtask

   function automatic logic [7:0] pick_letter();
      case ($urandom_range(8))
         0:       return CHAR_A;
         1:       return CHAR_B;
         2:       return CHAR_C;
         3:       return CHAR_D;
         4:       return CHAR_F;
         5:       return CHAR_L;
         6:       return CHAR_T;
         7:       return CHAR_DASH;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // Builds a frame that fits the current mode, optionally with an error marker.
   task automatic add_frame(input int n_pay, input bit mark_error, input bit good_sum);
      logic [7:0] bytes_q[$];
      logic [7:0] sum;
      logic [7:0] b;
      int         i;
      int         at;
      sum = '0;
      bytes_q.push_back(8'($urandom_range(255)));
      if (mode_q[0]) begin
         i = ($urandom_range(3) == 0) ? $urandom_range(65535) : n_pay;
         bytes_q.push_back(i[15:8]);
         bytes_q.push_back(i[7:0]);
      end
      for (i = 0; i < n_pay; i++) begin
         b = 8'($urandom_range(255));
         sum = sum + b;
         bytes_q.push_back(b);
      end
      if (mode_q[1]) bytes_q.push_back(good_sum ? sum : 8'($urandom_range(255)));
      bytes_q.push_back(8'($urandom_range(255)));
      if (mark_error) begin
         at = $urandom_range(bytes_q.size() - 1);
         bytes_q[at] = CHAR_DASH;
         if (at + 1 < bytes_q.size()) bytes_q[at + 1] = pick_letter();
      end
      foreach (bytes_q[k]) add_beat(bytes_q[k], k == bytes_q.size() - 1);
   endtask

   // Mostly well-formed frames, mixed at random with short frames and loose noise.
   task automatic fill_phase(input int count);
      int target;
      int pick;
      int n;
      int k;
      target = beats_queued + count;
      while (beats_queued < target) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(17, 60) : $urandom_range(0, 16);
            add_frame(n, $urandom_range(99) < 15, $urandom_range(4) != 0);
         end else if (pick < 82) begin
            n = $urandom_range(1, 1 + 2 * mode_q[0] + mode_q[1]);
            for (k = 0; k < n; k++) add_beat(8'($urandom_range(255)), k == n - 1);
         end else begin
            n = $urandom_range(1, 24);
            for (k = 0; k < n; k++) begin
               add_beat(8'($urandom_range(255)), $urandom_range(7) == 0);
            end
         end
      end
      add_beat(8'($urandom_range(255)), 1'b1);
   endtask

   // Waits until every byte is sent and every expected beat is back, then lets it settle.
   task automatic wait_drained();
      while (pending_beats.size() != 0 || req_valid || expected_beats.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (addr == MODE_ADDR) mode_q = data[1:0];
   endtask

   task automatic csr_check_mode();
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= MODE_ADDR;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      check_field("protocol_mode", mode_q, prdata[1:0]);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   // Sets a new framing mode, sometimes with a write to an unused address after it.
   task automatic set_mode(input logic [1:0] m);
      logic [31:0] word;
      word = $urandom;
      word[1:0] = m;
      csr_write(MODE_ADDR, word);
      if ($urandom_range(1) == 1) csr_write(UNUSED_ADDR, $urandom);
      csr_check_mode();
   endtask

   // Test sequence.
   initial begin
      logic [1:0] mode_list[8];
      int         p;
      mode_list = '{2'd1, 2'd2, 2'd3, 2'd0, 2'd3, 2'd2, 2'd1, 2'd0};
      @(negedge reset);
      @(negedge clock);

      // Reset mode (no length, no checksum): a lone stop byte is too short.
      add_beat(8'h00, 1'b1);
      // Smallest and largest byte values as payload.
      add_beat(8'h00, 1'b0);
      add_beat(8'hFF, 1'b0);
      add_beat(8'h00, 1'b0);
      add_beat(8'hFF, 1'b1);
      // Marker followed by a known letter.
      add_beat(8'h7E, 1'b0);
      add_beat(CHAR_DASH, 1'b0);
      add_beat(CHAR_L, 1'b0);
      add_beat(8'h0D, 1'b1);
      // Marker on the final byte, so no letter follows.
      add_beat(8'h7E, 1'b0);
      add_beat(CHAR_A, 1'b0);
      add_beat(CHAR_DASH, 1'b1);
      // Two markers in a row: the second is the letter, a later one is ignored.
      add_beat(8'h7E, 1'b0);
      add_beat(CHAR_DASH, 1'b0);
      add_beat(CHAR_DASH, 1'b0);
      add_beat(CHAR_DASH, 1'b0);
      add_beat(CHAR_C, 1'b1);
      wait_drained();

      // Full framing: one byte short of well formed, then an empty payload.
      set_mode(2'd3);
      add_beat(8'h02, 1'b0);
      add_beat(8'h00, 1'b0);
      add_beat(8'h00, 1'b0);
      add_beat(8'h03, 1'b1);
      add_beat(8'h02, 1'b0);
      add_beat(8'hFF, 1'b0);
      add_beat(8'hFF, 1'b0);
      add_beat(8'h00, 1'b0);
      add_beat(8'h03, 1'b1);
      wait_drained();

      // Random phases, one per mode setting.
      for (p = 0; p < 8; p++) begin
         set_mode(mode_list[p]);
         fill_phase(170);
         wait_drained();
      end

      // One long frame sent without idling on either side.
      set_mode(2'd3);
      steady = 1'b1;
      add_frame(LONG_FRAME_LEN, 1'b0, 1'b1);
      wait_drained();
      steady = 1'b0;

      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Run covered %0d input beats in all four framing modes, with one long frame.",
               beats_in);
      $display("Checked %0d payload beats and %0d status beats.", payload_beats, status_beats);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

/* files.f */
src/rfd_pkg.sv
src/rfd_front.sv
src/rfd_queue.sv
src/rfd_back.sv
src/response_frame_decoder.sv
tb/testbench.sv
